[design/hkrd_pkg.sv]
// ----------------------------------------------------------------------------
// hkrd_pkg
// Shared types and constants of the keyboard report differ: report and
// result layouts, event kinds and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package hkrd_pkg;

	localparam int NUM_SLOTS  = 6;
	localparam int SLOT_IDX_W = 3;
	localparam int CODE_W     = 8;
	localparam int MOD_BITS   = 8;

	localparam logic [CODE_W-1:0] MOD_CODE_BASE = 8'h80;

	localparam logic [1:0] KIND_RAW     = 2'd0;
	localparam logic [1:0] KIND_PRESS   = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAW_ENABLED = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIXED_MODE  = 1'b1;

	typedef logic [NUM_SLOTS-1:0][CODE_W-1:0] keys_t;

	typedef struct packed {
		logic [7:0] modifiers;
		logic [7:0] key_slot_0;
		logic [7:0] key_slot_1;
		logic [7:0] key_slot_2;
		logic [7:0] key_slot_3;
		logic [7:0] key_slot_4;
		logic [7:0] key_slot_5;
	} in_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [7:0] event_code;
		logic [7:0] raw_modifiers;
		logic [7:0] raw_key_0;
		logic [7:0] raw_key_1;
		logic [7:0] raw_key_2;
		logic [7:0] raw_key_3;
		logic [7:0] raw_key_4;
		logic [7:0] raw_key_5;
		logic       last_of_run;
	} out_t;

	typedef struct packed {
		logic raw_enabled;
		logic mixed_mode;
	} cfg_t;

	// result handed from the sequencer to the output register
	typedef struct packed {
		logic valid;
		out_t data;
	} push_t;

endpackage

`default_nettype wire

[design/hkrd_match.sv]
// ----------------------------------------------------------------------------
// hkrd_match
// Shared compare unit: reports whether a key code is held in any of the six
// slots of a report.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrd_match
	import hkrd_pkg::*;
(
	input  wire logic [CODE_W-1:0] code,
	input  wire keys_t             slots,
	output logic                   hit
);

	logic [NUM_SLOTS-1:0] eq;

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			eq[i] = (slots[i] == code);
		end
	end

	assign hit = |eq;

endmodule

`default_nettype wire

[design/hkrd_seq.sv]
// ----------------------------------------------------------------------------
// hkrd_seq
// Step sequencer: walks raw, modifier bits, old and new slots one step per
// cycle unless a held result waits on the output; the shared compare unit
// checks old and new slots. One result is held back to mark the report's final one.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrd_seq
	import hkrd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire in_t   in_data,
	input  wire cfg_t  cfg,
	input  wire logic  push_ok,
	output push_t      push
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RAW   = 3'd1;
	localparam logic [2:0] S_MOD   = 3'd2;
	localparam logic [2:0] S_OLD   = 3'd3;
	localparam logic [2:0] S_NEW   = 3'd4;
	localparam logic [2:0] S_FLUSH = 3'd5;

	logic [2:0]            state_q;
	logic [SLOT_IDX_W-1:0] idx_q;
	logic [7:0]            cur_mods_q;
	keys_t                 cur_keys_q;
	logic [7:0]            prev_mods_q;
	keys_t                 prev_keys_q;
	out_t                  pend_q;
	logic                  pend_valid_q;

	logic [CODE_W-1:0] code_sel;
	keys_t             slots_sel;
	logic              hit;
	logic              found;
	out_t              res;
	logic              advance;
	logic              bit_now;
	logic              bit_before;
	keys_t             in_keys;

	assign in_keys = {in_data.key_slot_5, in_data.key_slot_4, in_data.key_slot_3,
		in_data.key_slot_2, in_data.key_slot_1, in_data.key_slot_0};

	assign in_stall = (state_q != S_IDLE);

	// operand select for the compare unit
	always_comb begin
		if (state_q == S_NEW) begin
			code_sel  = cur_keys_q[idx_q];
			slots_sel = prev_keys_q;
		end else begin
			code_sel  = prev_keys_q[idx_q];
			slots_sel = cur_keys_q;
		end
	end

	hkrd_match u_match (
		.code  (code_sel),
		.slots (slots_sel),
		.hit   (hit)
	);

	assign bit_now    = cur_mods_q[idx_q];
	assign bit_before = prev_mods_q[idx_q];

	always_comb begin
		found = 1'b0;
		res   = '0;
		case (state_q)
			S_RAW: begin
				found             = 1'b1;
				res.event_kind    = KIND_RAW;
				res.raw_modifiers = cur_mods_q;
				res.raw_key_0     = cur_keys_q[0];
				res.raw_key_1     = cur_keys_q[1];
				res.raw_key_2     = cur_keys_q[2];
				res.raw_key_3     = cur_keys_q[3];
				res.raw_key_4     = cur_keys_q[4];
				res.raw_key_5     = cur_keys_q[5];
			end
			S_MOD: begin
				found          = (bit_now != bit_before);
				res.event_kind = bit_now ? KIND_PRESS : KIND_RELEASE;
				res.event_code = MOD_CODE_BASE + {{(CODE_W-SLOT_IDX_W){1'b0}}, idx_q};
			end
			S_OLD: begin
				found          = (code_sel != '0) && !hit;
				res.event_kind = KIND_RELEASE;
				res.event_code = code_sel;
			end
			S_NEW: begin
				found          = (code_sel != '0) && !hit;
				res.event_kind = KIND_PRESS;
				res.event_code = code_sel;
			end
			default: ;
		endcase
	end

	// a new result needs the held one sent out first
	assign advance = !(found && pend_valid_q && !push_ok);

	always_comb begin
		push.valid            = pend_valid_q && push_ok && (found || state_q == S_FLUSH);
		push.data             = pend_q;
		push.data.last_of_run = (state_q == S_FLUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			prev_mods_q  <= '0;
			prev_keys_q  <= '0;
		end else begin
			if (found && advance) begin
				pend_valid_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= cfg.raw_enabled ? S_RAW : S_MOD;
						idx_q   <= '0;
					end
				end
				S_RAW: begin
					state_q <= cfg.mixed_mode ? S_MOD : S_FLUSH;
					idx_q   <= '0;
				end
				S_MOD: begin
					if (advance) begin
						if (idx_q == SLOT_IDX_W'(MOD_BITS - 1)) begin
							state_q <= S_OLD;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_OLD: begin
					if (advance) begin
						if (idx_q == SLOT_IDX_W'(NUM_SLOTS - 1)) begin
							state_q <= S_NEW;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_NEW: begin
					if (advance) begin
						if (idx_q == SLOT_IDX_W'(NUM_SLOTS - 1)) begin
							state_q     <= S_FLUSH;
							idx_q       <= '0;
							prev_mods_q <= cur_mods_q;
							prev_keys_q <= cur_keys_q;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q || push_ok) begin
						state_q      <= S_IDLE;
						pend_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cur_mods_q <= in_data.modifiers;
			cur_keys_q <= in_keys;
		end
		if (found && advance) begin
			pend_q <= res;
		end
	end

	a_no_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (state_q != S_IDLE))
		else $error("result pushed while idle");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("held result left behind at end of report");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && push.data.last_of_run) |=> (state_q == S_IDLE))
		else $error("last result sent but report still in progress");

	a_prev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_NEW) |=> ($stable(prev_keys_q) && $stable(prev_mods_q)))
		else $error("stored report changed outside the press scan");

endmodule

`default_nettype wire

[design/hid_keyboard_report_differ_unit.sv]
// A found result is held until the next one is found or the flush step, then is
// registered into out_data. Each report runs 8 modifier, 6 release, 6 press and
// 1 flush step, plus a raw step in raw and mixed mode; raw only runs raw and flush.
// A held result waiting on out_stall holds the steps; in_stall stays high until done.
// The six-slot compare unit is shared by all release and press steps.
// Reset clears the stored report to zero and both registers to off.
// ----------------------------------------------------------------------------
// hid_keyboard_report_differ_unit
// Boot-keyboard report differ: turns each report into raw, press and release
// transactions against the previously stored report.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_keyboard_report_differ_unit
	import hkrd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic                 cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_t                  in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_t                      out_data
);

	cfg_t  cfg_q;
	logic  out_valid_q;
	out_t  out_q;
	logic  push_ok;
	push_t push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RAW_ENABLED: cfg_q.raw_enabled <= cfg_data;
				CFG_MIXED_MODE:  cfg_q.mixed_mode  <= cfg_data;
				default: ;
			endcase
		end
	end

	hkrd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.push_ok  (push_ok),
		.push     (push)
	);

	// output register frees up in the same cycle its transaction completes
	assign push_ok = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			out_q <= push.data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds boot-keyboard reports to hid_keyboard_report_differ_unit under every
// raw/mixed register setting, with random idle on input and stall on output.
// A scoreboard predicts the raw, press and release transactions of each
// report and checks them in order as they leave the block.
// ----------------------------------------------------------------------------

module testbench;
	import hkrd_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned BLOCK_ITEMS  = 26;

	class key_event_board;
		out_t        pending_events[$];
		logic [7:0]  held_mods;
		keys_t       held_keys;
		bit          raw_on;
		bit          mixed_on;
		int unsigned errors;

		function new();
			held_mods = '0;
			held_keys = '0;
			raw_on    = 1'b0;
			mixed_on  = 1'b0;
			errors    = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic val);
			if (idx == CFG_RAW_ENABLED) begin
				raw_on = val;
			end else if (idx == CFG_MIXED_MODE) begin
				mixed_on = val;
			end
		endfunction

		static function bit holds(keys_t slots, logic [7:0] code);
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (slots[i] == code) begin
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		static function out_t key_event(logic [1:0] kind, logic [7:0] code);
			out_t ev;
			ev            = '0;
			ev.event_kind = kind;
			ev.event_code = code;
			return ev;
		endfunction

		// called on every accepted report transaction
		function void note_report(in_t r);
			keys_t now_keys;
			out_t  run [22];
			int    n;
			n        = 0;
			now_keys = {r.key_slot_5, r.key_slot_4, r.key_slot_3,
				r.key_slot_2, r.key_slot_1, r.key_slot_0};
			if (raw_on) begin
				run[0]               = '0;
				run[0].event_kind    = KIND_RAW;
				run[0].raw_modifiers = r.modifiers;
				run[0].raw_key_0     = r.key_slot_0;
				run[0].raw_key_1     = r.key_slot_1;
				run[0].raw_key_2     = r.key_slot_2;
				run[0].raw_key_3     = r.key_slot_3;
				run[0].raw_key_4     = r.key_slot_4;
				run[0].raw_key_5     = r.key_slot_5;
				n = 1;
			end
			// raw-only mode leaves the stored report untouched
			if (!(raw_on && !mixed_on)) begin
				for (int b = 0; b < MOD_BITS; b++) begin
					if (r.modifiers[b] != held_mods[b]) begin
						run[n] = key_event(r.modifiers[b] ? KIND_PRESS : KIND_RELEASE,
							MOD_CODE_BASE + 8'(b));
						n++;
					end
				end
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (held_keys[i] != '0 && !holds(now_keys, held_keys[i])) begin
						run[n] = key_event(KIND_RELEASE, held_keys[i]);
						n++;
					end
				end
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (now_keys[i] != '0 && !holds(held_keys, now_keys[i])) begin
						run[n] = key_event(KIND_PRESS, now_keys[i]);
						n++;
					end
				end
				held_mods = r.modifiers;
				held_keys = now_keys;
			end
			if (n > 0) begin
				run[n-1].last_of_run = 1'b1;
			end
			for (int i = 0; i < n; i++) begin
				pending_events.push_back(run[i]);
			end
		endfunction

		function void report_bad(string what, out_t want, out_t got);
			errors++;
			if (errors <= 10) begin
				$display("tb: %s at %0t", what, $realtime);
				$display("  expected %p", want);
				$display("  actual   %p", got);
			end
		endfunction

		function void check_event(out_t got);
			out_t want;
			if (pending_events.size() == 0) begin
				report_bad("unexpected transaction", '0, got);
				return;
			end
			want = pending_events.pop_front();
			if (got.event_kind !== want.event_kind || got.event_code !== want.event_code ||
				got.raw_modifiers !== want.raw_modifiers ||
				got.raw_key_0 !== want.raw_key_0 || got.raw_key_1 !== want.raw_key_1 ||
				got.raw_key_2 !== want.raw_key_2 || got.raw_key_3 !== want.raw_key_3 ||
				got.raw_key_4 !== want.raw_key_4 || got.raw_key_5 !== want.raw_key_5 ||
				got.last_of_run !== want.last_of_run) begin
				report_bad("mismatch", want, got);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic                 cfg_data  = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_t                  in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_t                 out_data;

	int unsigned    send_idle_pct = 0;
	int unsigned    stall_pct     = 0;
	int unsigned    cycle_count   = 0;
	in_t            last_sent     = '0;
	key_event_board board;

	hid_keyboard_report_differ_unit dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			board.check_event(out_data);
		end
	end

	task automatic send_report(input in_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		board.note_report(r);
		last_sent = r;
	endtask

	// hold off input until the block has emptied, plus its busy window
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic raw, input logic mixed);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_RAW_ENABLED;
		cfg_data  <= raw;
		@(posedge clk);
		board.set_reg(CFG_RAW_ENABLED, raw);
		cfg_index <= CFG_MIXED_MODE;
		cfg_data  <= mixed;
		@(posedge clk);
		board.set_reg(CFG_MIXED_MODE, mixed);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		in_t        rep;
		keys_t      ks;
		logic [7:0] mods;
		int unsigned m;
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 36;
		stall_pct     = 69;
		// registers come out of reset off: plain diff
		send_report(in_t'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
		send_report(in_t'{8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09});
		send_report(in_t'{8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09});
		send_report(in_t'{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_report(in_t'{8'hA5, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h80});
		send_report(in_t'{8'h5A, 8'h03, 8'h03, 8'h01, 8'h00, 8'h00, 8'hFF});
		send_report(in_t'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
		settle();
		set_mode(1'b1, 1'b0);
		send_report(in_t'{8'h12, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
		send_report(in_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		settle();
		set_mode(1'b1, 1'b1);
		send_report(in_t'{8'h12, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
		send_report(in_t'{8'h12, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
		send_report(in_t'{8'hED, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F});
		send_report(in_t'{8'h12, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15});
		send_report(in_t'{8'h80, 8'h00, 8'h04, 8'h05, 8'h00, 8'h00, 8'h00});
		settle();
		set_mode(1'b0, 1'b1);
		send_report(in_t'{8'h01, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE0});
		send_report(in_t'{8'h01, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE0});

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 36;
					stall_pct     = 69;
				end
				1: begin
					send_idle_pct = 69;
					stall_pct     = 36;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				settle();
				m = (blk + ph) % 4;
				set_mode(m == 1 || m == 2, m[0]);
				for (int k = 0; k < BLOCK_ITEMS; k++) begin
					if ($urandom_range(9) == 0) begin
						rep = in_t'({$urandom(), 24'($urandom())});
					end else begin
						// typical typing: keys held, lifted or added against the last report
						mods = last_sent.modifiers;
						ks   = {last_sent.key_slot_5, last_sent.key_slot_4,
							last_sent.key_slot_3, last_sent.key_slot_2,
							last_sent.key_slot_1, last_sent.key_slot_0};
						if ($urandom_range(3) == 0) begin
							mods = 8'($urandom());
						end else if ($urandom_range(1) == 0) begin
							mods[$urandom_range(7)] = ~mods[$urandom_range(7)];
						end
						for (int i = 0; i < NUM_SLOTS; i++) begin
							case ($urandom_range(9))
								0, 1, 2: ks[i] = ks[i];
								3, 4, 5: ks[i] = '0;
								6, 7, 8: ks[i] = 8'($urandom_range(4, 11));
								default: ks[i] = 8'($urandom_range(1, 255));
							endcase
						end
						rep.modifiers  = mods;
						rep.key_slot_0 = ks[0];
						rep.key_slot_1 = ks[1];
						rep.key_slot_2 = ks[2];
						rep.key_slot_3 = ks[3];
						rep.key_slot_4 = ks[4];
						rep.key_slot_5 = ks[5];
					end
					send_report(rep);
					if ($urandom_range(24) == 0) begin
						settle();
					end
				end
			end
		end

		settle();
		if (board.errors == 0 && board.pending_events.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[hid_keyboard_report_differ_unit.f]
design/hkrd_pkg.sv
design/hkrd_match.sv
design/hkrd_seq.sv
design/hid_keyboard_report_differ_unit.sv
sim/testbench.sv
